@@ sv/intrusion_alarm_controller_macros.svh @@
// Assertion helpers shared by the alarm controller modules.
// Each macro expects the clock aclk and the active-low reset aresetn in scope.
`ifndef INTRUSION_ALARM_CONTROLLER_MACROS_SVH
`define INTRUSION_ALARM_CONTROLLER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IAC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IAC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/iac_pkg.sv @@
`default_nettype none

package iac_pkg;

    // Item kinds carried in tuser.
    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_DOOR = 2'd1;
    localparam logic [1:0] KIND_IR   = 2'd2;

    // Master command codes.
    localparam logic [1:0] CMD_DISARM  = 2'd0;
    localparam logic [1:0] CMD_ARM     = 2'd1;
    localparam logic [1:0] CMD_TRIGGER = 2'd2;

    // System modes.
    localparam logic [1:0] MODE_DISARMED = 2'd0;
    localparam logic [1:0] MODE_ARMED    = 2'd1;
    localparam logic [1:0] MODE_ALARM    = 2'd2;

    // Configuration register indexes.
    localparam int          CFG_ADDR_W = 3;
    localparam int          CFG_DATA_W = 16;
    localparam logic [2:0]  CFG_IR_THRESHOLD  = 3'd0;
    localparam logic [2:0]  CFG_SERVO_CLOSED  = 3'd1;
    localparam logic [2:0]  CFG_SERVO_OPEN    = 3'd2;
    localparam logic [2:0]  CFG_DOOR_LOCKOUT  = 3'd3;
    localparam logic [2:0]  CFG_ALARM_DUR     = 3'd4;
    localparam logic [2:0]  CFG_IR_COOLDOWN   = 3'd5;
    localparam logic [2:0]  CFG_BLINK_SLOW    = 3'd6;
    localparam logic [2:0]  CFG_BLINK_FAST    = 3'd7;

    // Register reset values.
    localparam logic [9:0]  IR_THRESHOLD_RST = 10'd500;
    localparam logic [11:0] SERVO_CLOSED_RST = 12'd188;
    localparam logic [11:0] SERVO_OPEN_RST   = 12'd300;
    localparam logic [9:0]  DOOR_LOCKOUT_RST = 10'd200;
    localparam logic [15:0] ALARM_DUR_RST    = 16'd5000;
    localparam logic [15:0] IR_COOLDOWN_RST  = 16'd2000;
    localparam logic [9:0]  BLINK_SLOW_RST   = 10'd250;
    localparam logic [9:0]  BLINK_FAST_RST   = 10'd62;

    // Sample divider width covers any sample period up to 63.
    localparam int DIV_W = 6;

    // Stream widths.
    localparam int IN_DATA_W  = 16;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 24;

    typedef struct packed {
        logic [9:0]  ir_threshold;
        logic [11:0] servo_closed_pos;
        logic [11:0] servo_open_pos;
        logic [9:0]  door_lockout_ticks;
        logic [15:0] alarm_duration_ticks;
        logic [15:0] ir_cooldown_ticks;
        logic [9:0]  blink_slow_half;
        logic [9:0]  blink_fast_half;
    } cfg_t;

    typedef struct packed {
        logic [1:0] command_code;
        logic       command_valid;
        logic [9:0] ir_sample;
        logic [1:0] kind;
    } item_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic        sample_request;
        logic        status_alarm;
        logic        led_on;
        logic [11:0] servo_pos;
    } result_t;

endpackage

`default_nettype wire

@@ sv/iac_cfg_regs.sv @@
`default_nettype none

module iac_cfg_regs (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [iac_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [iac_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output iac_pkg::cfg_t                        cfg
);
    import iac_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write; each value is masked to its register width.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_addr)
                CFG_IR_THRESHOLD: cfg_next.ir_threshold         = cfg_wdata[9:0];
                CFG_SERVO_CLOSED: cfg_next.servo_closed_pos     = cfg_wdata[11:0];
                CFG_SERVO_OPEN:   cfg_next.servo_open_pos       = cfg_wdata[11:0];
                CFG_DOOR_LOCKOUT: cfg_next.door_lockout_ticks   = cfg_wdata[9:0];
                CFG_ALARM_DUR:    cfg_next.alarm_duration_ticks = cfg_wdata[15:0];
                CFG_IR_COOLDOWN:  cfg_next.ir_cooldown_ticks    = cfg_wdata[15:0];
                CFG_BLINK_SLOW:   cfg_next.blink_slow_half      = cfg_wdata[9:0];
                CFG_BLINK_FAST:   cfg_next.blink_fast_half      = cfg_wdata[9:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ir_threshold         <= IR_THRESHOLD_RST;
            cfg_reg.servo_closed_pos     <= SERVO_CLOSED_RST;
            cfg_reg.servo_open_pos       <= SERVO_OPEN_RST;
            cfg_reg.door_lockout_ticks   <= DOOR_LOCKOUT_RST;
            cfg_reg.alarm_duration_ticks <= ALARM_DUR_RST;
            cfg_reg.ir_cooldown_ticks    <= IR_COOLDOWN_RST;
            cfg_reg.blink_slow_half      <= BLINK_SLOW_RST;
            cfg_reg.blink_fast_half      <= BLINK_FAST_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ sv/iac_engine.sv @@
`default_nettype none

`include "intrusion_alarm_controller_macros.svh"

module iac_engine #(
    parameter int SAMPLE_PERIOD = 40,
    parameter int TIME_WIDTH    = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        step_en,
    input  iac_pkg::item_t   item,
    input  iac_pkg::cfg_t    cfg,
    output iac_pkg::result_t result
);
    import iac_pkg::*;

    // Elapsed times are compared at the wider of the time count and the registers.
    localparam int CMP_W = (TIME_WIDTH > 16) ? TIME_WIDTH : 16;

    logic [TIME_WIDTH-1:0] time_reg,        time_next;
    logic                  door_flag_reg,   door_flag_next;
    logic                  ir_flag_reg,     ir_flag_next;
    logic [9:0]            door_timer_reg,  door_timer_next;
    logic [15:0]           cooldown_reg,    cooldown_next;
    logic                  sampling_reg,    sampling_next;
    logic [DIV_W-1:0]      divider_reg,     divider_next;
    logic [1:0]            mode_reg,        mode_next;
    logic                  status_reg,      status_next;
    logic                  led_reg,         led_next;
    logic [TIME_WIDTH-1:0] last_toggle_reg, last_toggle_next;
    logic [TIME_WIDTH-1:0] start_reg,       start_next;
    logic                  latched_reg,     latched_next;
    logic [11:0]           servo_reg,       servo_next;

    logic                  req;
    logic                  sensor_alarm;
    logic                  alarm_shown;
    logic [9:0]            half;
    logic [TIME_WIDTH-1:0] since_toggle;
    logic [TIME_WIDTH-1:0] since_start;

    // Single-pass update of the node state for one item.
    always_comb begin
        time_next        = time_reg;
        door_flag_next   = door_flag_reg;
        ir_flag_next     = ir_flag_reg;
        door_timer_next  = door_timer_reg;
        cooldown_next    = cooldown_reg;
        sampling_next    = sampling_reg;
        divider_next     = divider_reg;
        mode_next        = mode_reg;
        status_next      = status_reg;
        led_next         = led_reg;
        last_toggle_next = last_toggle_reg;
        start_next       = start_reg;
        latched_next     = latched_reg;
        servo_next       = servo_reg;
        req              = 1'b0;
        sensor_alarm     = 1'b0;
        alarm_shown      = 1'b0;
        half             = cfg.blink_fast_half;
        since_toggle     = '0;
        since_start      = '0;

        case (item.kind)
            KIND_TICK: begin
                // Time base and countdown timers.
                time_next = time_reg + 1'b1;
                if (door_timer_reg != '0) begin
                    door_timer_next = door_timer_reg - 1'b1;
                end
                if (cooldown_reg != '0) begin
                    cooldown_next = cooldown_reg - 1'b1;
                end

                // Periodic IR sample request while sampling is on (after arm or trigger) and not cooling down.
                if (sampling_reg && cooldown_next == '0) begin
                    divider_next = divider_reg + 1'b1;
                    if (divider_next >= DIV_W'(SAMPLE_PERIOD)) begin
                        divider_next = '0;
                        req          = 1'b1;
                    end
                end

                // Master command.
                if (item.command_valid) begin
                    case (item.command_code)
                        CMD_DISARM: begin
                            mode_next      = MODE_DISARMED;
                            status_next    = 1'b0;
                            sampling_next  = 1'b0;
                            door_flag_next = 1'b0;
                            ir_flag_next   = 1'b0;
                            cooldown_next  = '0;
                            latched_next   = 1'b0;
                            servo_next     = cfg.servo_closed_pos;
                            led_next       = 1'b0;
                        end
                        CMD_ARM: begin
                            mode_next     = MODE_ARMED;
                            status_next   = 1'b0;
                            sampling_next = 1'b1;
                        end
                        CMD_TRIGGER: begin
                            mode_next     = MODE_ALARM;
                            sampling_next = 1'b1;
                        end
                        default: begin
                            mode_next = mode_next;
                        end
                    endcase
                end

                // Alarm judgment.
                sensor_alarm = (door_flag_next || ir_flag_next) && (mode_next != MODE_DISARMED);
                alarm_shown  = sensor_alarm || (mode_next == MODE_ALARM);

                if (sensor_alarm) begin
                    status_next = 1'b1;
                    if (!latched_next) begin
                        latched_next = 1'b1;
                        start_next   = time_next;
                    end
                end

                since_toggle = time_next - last_toggle_next;
                since_start  = time_next - start_next;

                if (alarm_shown) begin
                    half       = (sensor_alarm && door_flag_next) ? cfg.blink_slow_half
                                                                  : cfg.blink_fast_half;
                    servo_next = cfg.servo_open_pos;
                    if (CMP_W'(since_toggle) >= CMP_W'(half)) begin
                        last_toggle_next = time_next;
                        led_next         = !led_next;
                    end
                    // Local alarm clears itself and starts the IR cooldown.
                    if (sensor_alarm &&
                        CMP_W'(since_start) >= CMP_W'(cfg.alarm_duration_ticks)) begin
                        door_flag_next = 1'b0;
                        ir_flag_next   = 1'b0;
                        cooldown_next  = cfg.ir_cooldown_ticks;
                        status_next    = 1'b0;
                        latched_next   = 1'b0;
                    end
                end else begin
                    servo_next   = cfg.servo_closed_pos;
                    led_next     = 1'b0;
                    latched_next = 1'b0;
                end
            end
            KIND_DOOR: begin
                // A press outside the lockout window raises the door flag.
                if (door_timer_reg == '0) begin
                    door_flag_next  = 1'b1;
                    door_timer_next = cfg.door_lockout_ticks;
                end
            end
            KIND_IR: begin
                if (item.ir_sample > cfg.ir_threshold) begin
                    ir_flag_next = 1'b1;
                end
            end
            default: begin
                req = 1'b0;
            end
        endcase
    end

    // State registers advance once per processed item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_reg        <= '0;
            door_flag_reg   <= 1'b0;
            ir_flag_reg     <= 1'b0;
            door_timer_reg  <= '0;
            cooldown_reg    <= '0;
            sampling_reg    <= 1'b0;
            divider_reg     <= '0;
            mode_reg        <= MODE_DISARMED;
            status_reg      <= 1'b0;
            led_reg         <= 1'b0;
            last_toggle_reg <= '0;
            start_reg       <= '0;
            latched_reg     <= 1'b0;
            servo_reg       <= SERVO_CLOSED_RST;
        end else if (step_en) begin
            time_reg        <= time_next;
            door_flag_reg   <= door_flag_next;
            ir_flag_reg     <= ir_flag_next;
            door_timer_reg  <= door_timer_next;
            cooldown_reg    <= cooldown_next;
            sampling_reg    <= sampling_next;
            divider_reg     <= divider_next;
            mode_reg        <= mode_next;
            status_reg      <= status_next;
            led_reg         <= led_next;
            last_toggle_reg <= last_toggle_next;
            start_reg       <= start_next;
            latched_reg     <= latched_next;
            servo_reg       <= servo_next;
        end
    end

    // The result shows the state as it stands after this item.
    always_comb begin
        result.servo_pos      = servo_next;
        result.led_on         = led_next;
        result.status_alarm   = status_next;
        result.sample_request = req;
        result.mode           = mode_next;
    end

    // A raised status or a lit LED never coexists with a disarmed node.
    `IAC_ASSERT_NOW(a_status_needs_mode, status_reg, mode_reg != MODE_DISARMED,
                    "status flag set while disarmed")
    `IAC_ASSERT_NOW(a_led_needs_mode, led_reg, mode_reg != MODE_DISARMED,
                    "LED lit while disarmed")
    `IAC_ASSERT_NOW(a_req_on_tick, step_en && req, item.kind == KIND_TICK,
                    "sample request raised by a non-tick item")

endmodule

`default_nettype wire

@@ sv/intrusion_alarm_controller.sv @@
// Datapath: an accepted item waits in the input register, and its result in the result
// register, before the result is offered. The whole state update is one pass of logic.
// Throughput: one item per cycle while m_tready does not stall the output.
// Reset: synchronous, active low; state clears, registers take their defaults.
// The block accepts items in the first cycle after reset is released.
`default_nettype none

`include "intrusion_alarm_controller_macros.svh"

module intrusion_alarm_controller #(
    parameter int SAMPLE_PERIOD = 40,
    parameter int TIME_WIDTH    = 16
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // Input item stream.
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // tdata: ir_sample [9:0], command_valid [10], command_code [12:11], zero pad [15:13]
    input  wire logic [iac_pkg::IN_DATA_W-1:0]   s_tdata,
    // tuser: kind [1:0]
    input  wire logic [iac_pkg::IN_USER_W-1:0]   s_tuser,
    // Result stream.
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // tdata: servo_pos [11:0], led_on [12], status_alarm [13], sample_request [14],
    //        mode [16:15], zero pad [23:17]
    output logic [iac_pkg::OUT_DATA_W-1:0]       m_tdata,
    // Configuration writes.
    input  wire logic                            cfg_we,
    input  wire logic [iac_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [iac_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import iac_pkg::*;

    cfg_t    cfg;
    item_t   in_item_reg;
    item_t   in_item_next;
    logic    in_valid_reg;
    logic    in_valid_next;
    result_t step_result;
    result_t out_reg;
    result_t out_next;
    logic    out_valid_reg;
    logic    out_valid_next;
    logic    s_accept;
    logic    advance;

    iac_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    iac_engine #(
        .SAMPLE_PERIOD (SAMPLE_PERIOD),
        .TIME_WIDTH    (TIME_WIDTH)
    ) u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (step_result)
    );

    // Handshake: the input register drains whenever the result register can take an item.
    always_comb begin
        advance  = in_valid_reg && (!out_valid_reg || m_tready);
        s_tready = !in_valid_reg || advance;
        s_accept = s_tvalid && s_tready;

        in_item_next.kind          = s_tuser[1:0];
        in_item_next.ir_sample     = s_tdata[9:0];
        in_item_next.command_valid = s_tdata[10];
        in_item_next.command_code  = s_tdata[12:11];

        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end

        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end

        out_next = advance ? step_result : out_reg;
    end

    // Control flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg <= in_item_next;
        end
        out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_reg.mode, out_reg.sample_request, out_reg.status_alarm,
                       out_reg.led_on, out_reg.servo_pos};

    // A held item is not dropped while the result register is blocked.
    `IAC_ASSERT_NEXT(a_input_kept, in_valid_reg && out_valid_reg && !m_tready, in_valid_reg,
                     "pending item lost while output stalled")
    // The input side stalls only when both stages hold an item and m_tready is low.
    `IAC_ASSERT_NOW(a_stall_reason, !s_tready, in_valid_reg && out_valid_reg && !m_tready,
                    "input stalled without a full pipeline")
    // A taken result with nothing behind it empties the result register.
    `IAC_ASSERT_NEXT(a_output_drains, out_valid_reg && m_tready && !in_valid_reg, !m_tvalid,
                     "result repeated after it was taken")

endmodule

`default_nettype wire
